@@ rtl/ccmb_pkg.sv @@
package ccmb_pkg;

  localparam int SIZE_W   = 32;
  localparam int CARD_W   = 24;
  localparam int OFFSET_W = 8;
  localparam int FIRST_W  = 8;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OLD_GEN_SIZE   = 1'b0,
    REG_FIRST_OFFSET   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ACT_RESTART = 1'b0,
    ACT_OBJECT  = 1'b1
  } action_t;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] object_size;
  } in_t;

  typedef struct packed {
    logic [CARD_W-1:0]   card_index;
    logic [OFFSET_W-1:0] offset_units;
    logic                overrun;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } push_t;

endpackage

@@ rtl/ccmb_out_queue.sv @@
module ccmb_out_queue (
  input  logic           clk,
  input  logic           rst,
  input  ccmb_pkg::push_t push,
  input  logic           out_stall,
  output logic           out_valid,
  output ccmb_pkg::out_t out_data,
  output logic           room_for_two
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  ccmb_pkg::out_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             pop;

  assign out_valid    = count != '0;
  assign out_data     = entries[rd_ptr];
  assign pop          = out_valid && !out_stall;
  assign room_for_two = count <= (PTR_W+1)'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
    end
  end

endmodule

@@ rtl/card_crossing_map_builder_top.sv @@
// Crossing map builder: takes one object size per cycle while its input is not
// stalled and writes crossing map entries on the output channel, one entry per
// cycle while the output is not stalled. An object that ends the build after
// crossing a card gives two entries, which leave the queue in turn while the next
// request is already held. A request passes through an input register, then the
// position update (one add and the compares on the stored next object position,
// the loop that sets the one-per-cycle rate) which writes into a four-entry result
// queue. Input is held off only while the queue lacks room for two entries, so the
// sustained rate is one object per cycle when the output takes one entry per cycle.
module card_crossing_map_builder_top #(
  parameter int CARD_LOG2    = 8,
  parameter int OFFSET_SCALE = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ccmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccmb_pkg::SIZE_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ccmb_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ccmb_pkg::out_t                  out_data
);

  localparam int W      = ccmb_pkg::SIZE_W;
  localparam int L      = $clog2(OFFSET_SCALE);
  localparam int N      = 8 + L;
  localparam int S      = N + L;
  localparam int M      = ((1 << S) + OFFSET_SCALE - 1) / OFFSET_SCALE;
  localparam int SAT    = 256 * OFFSET_SCALE;
  localparam int PROD_W = N + S + 1;
  localparam logic [W-1:0] CARD_LOW  = W'((64'd1 << CARD_LOG2) - 64'd1);
  localparam logic [W:0]   CARD_SPAN = (W+1)'(64'd1 << CARD_LOG2);

  function automatic logic [ccmb_pkg::OFFSET_W-1:0] units(input logic [W-1:0] bytes);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(bytes[N-1:0]) * PROD_W'(M);
    if (bytes >= W'(SAT)) begin
      units = 8'hFF;
    end else begin
      units = prod[S+7:S];
    end
  endfunction

  logic [W-1:0]                  old_gen_size;
  logic [ccmb_pkg::FIRST_W-1:0]  first_object_offset;
  logic [W-1:0]                  pos;
  logic [W-1:0]                  pos_next;
  logic                          in_full;
  ccmb_pkg::in_t                 in_item;
  logic                          room_for_two;
  logic                          process;
  ccmb_pkg::push_t               push;

  logic [W-1:0] pos_m1;
  logic [W-1:0] card_base;
  logic [W-1:0] card_num;
  logic [W-1:0] end_m1;
  logic [W-1:0] end_base;
  logic [W-1:0] end_card;
  logic [W-1:0] start;
  logic [W:0]   next_raw;
  logic         ovr;
  logic         reach_end;
  logic         crossing;
  ccmb_pkg::out_t entry_cross;
  ccmb_pkg::out_t entry_final;

  assign process  = in_full && room_for_two;
  assign in_stall = in_full && !room_for_two;

  assign pos_m1    = pos - W'(1);
  assign card_base = (pos == '0) ? '0 : (pos_m1 & ~CARD_LOW);
  assign card_num  = (pos == '0) ? '0 : (pos_m1 >> CARD_LOG2);
  assign end_m1    = old_gen_size - W'(1);
  assign end_base  = end_m1 & ~CARD_LOW;
  assign end_card  = end_m1 >> CARD_LOG2;
  assign start     = (pos == '0) ? W'(first_object_offset) : pos;
  assign next_raw  = {1'b0, start} + {1'b0, in_item.object_size};
  assign reach_end = next_raw >= {1'b0, old_gen_size};
  assign crossing  = (reach_end ? {1'b0, old_gen_size} : next_raw) >
                     ({1'b0, card_base} + CARD_SPAN);

  always_comb begin
    push     = '0;
    pos_next = pos;
    ovr      = 1'b0;
    entry_cross.card_index   = card_num[ccmb_pkg::CARD_W-1:0];
    entry_cross.offset_units = units(start - card_base);
    entry_cross.overrun      = 1'b0;
    entry_cross.last         = 1'b1;
    entry_final.card_index   = end_card[ccmb_pkg::CARD_W-1:0];
    entry_final.offset_units = units(old_gen_size - end_base);
    entry_final.overrun      = 1'b0;
    entry_final.last         = 1'b1;
    if (process) begin
      if (in_item.action == ccmb_pkg::ACT_RESTART) begin
        pos_next = '0;
      end else if (pos < old_gen_size) begin
        if (start >= old_gen_size) begin
          ovr      = start > old_gen_size;
          pos_next = old_gen_size;
          entry_final.card_index   = card_num[ccmb_pkg::CARD_W-1:0];
          entry_final.offset_units = units(old_gen_size);
          entry_final.overrun      = ovr;
          push.count = 2'd1;
          push.first = entry_final;
        end else begin
          ovr      = next_raw > {1'b0, old_gen_size};
          pos_next = reach_end ? old_gen_size : next_raw[W-1:0];
          entry_cross.overrun = ovr;
          entry_cross.last    = !reach_end;
          entry_final.overrun = ovr;
          if (crossing && reach_end) begin
            push.count  = 2'd2;
            push.first  = entry_cross;
            push.second = entry_final;
          end else if (crossing) begin
            push.count = 2'd1;
            push.first = entry_cross;
          end else if (reach_end) begin
            push.count = 2'd1;
            push.first = entry_final;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      old_gen_size        <= '0;
      first_object_offset <= '0;
      pos                 <= '0;
      in_full             <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ccmb_pkg::REG_OLD_GEN_SIZE: old_gen_size        <= cfg_data;
          ccmb_pkg::REG_FIRST_OFFSET: first_object_offset <= cfg_data[ccmb_pkg::FIRST_W-1:0];
          default: ;
        endcase
      end
      pos <= pos_next;
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (process) begin
        in_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item <= in_data;
    end
  end

  ccmb_out_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .room_for_two (room_for_two)
  );

endmodule

@@ rtl/ccmb_checker.sv @@
module ccmb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input ccmb_pkg::out_t                 out_data
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result pending right after reset.");

  a_second_entry_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last |=> out_valid)
    else $error("Entry not marked last was not followed by another entry.");

  a_overrun_carried: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last && out_data.overrun |=>
      out_valid && out_data.overrun)
    else $error("Overrun flag differs between entries of one request.");

  a_output_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

endmodule

bind card_crossing_map_builder_top ccmb_checker u_checker (.*);

@@ tb/ccmb_tb_pkg.sv @@
`timescale 1ns / 1ps
package ccmb_tb_pkg;
  import ccmb_pkg::*;

  localparam int TB_CARD_LOG2    = 8;
  localparam int TB_OFFSET_SCALE = 4;

  class crossing_map_checker;
    bit [31:0] old_gen_size;
    bit [7:0]  first_offset;
    bit [63:0] next_pos;
    bit [23:0] cur_card;
    out_t      expected_entries[$];
    int        mismatches;

    function new();
      old_gen_size = '0;
      first_offset = '0;
      next_pos     = '0;
      cur_card     = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, bit [31:0] value);
      if (idx == REG_OLD_GEN_SIZE) begin
        old_gen_size = value;
      end else begin
        first_offset = value[7:0];
      end
    endfunction

    function bit build_complete();
      return next_pos >= {32'b0, old_gen_size};
    endfunction

    function int pending();
      return expected_entries.size();
    endfunction

    function bit [63:0] card_of(bit [63:0] pos);
      return (pos == 0) ? 64'd0 : (pos - 1) >> TB_CARD_LOG2;
    endfunction

    function bit [7:0] to_units(bit [63:0] bytes);
      bit [63:0] u;
      u = bytes / TB_OFFSET_SCALE;
      return (u > 255) ? 8'hFF : u[7:0];
    endfunction

    function void push_entry(bit [63:0] card, bit [63:0] bytes, bit ovr, bit last_flag);
      out_t e;
      e.card_index   = card[23:0];
      e.offset_units = to_units(bytes);
      e.overrun      = ovr;
      e.last         = last_flag;
      expected_entries.push_back(e);
    endfunction

    function void note_request(in_t req);
      bit [63:0] end_pos;
      bit [63:0] start;
      bit [63:0] card;
      bit [63:0] card_start;
      bit [63:0] nxt;
      bit        ovr;
      end_pos = {32'b0, old_gen_size};
      ovr     = 1'b0;
      if (req.action == ACT_RESTART) begin
        next_pos = '0;
        cur_card = '0;
        return;
      end
      if (next_pos >= end_pos) begin
        return;
      end
      card       = card_of(next_pos);
      start      = (next_pos == 0) ? {56'b0, first_offset} : next_pos;
      card_start = card << TB_CARD_LOG2;
      // The first object already lies at or past the end: only the final entry is written.
      if (start >= end_pos) begin
        ovr      = (start > end_pos);
        next_pos = end_pos;
        cur_card = card[23:0];
        push_entry(card, end_pos - card_start, ovr, 1'b1);
        return;
      end
      nxt = start + {32'b0, req.object_size};
      if (nxt > end_pos) begin
        nxt = end_pos;
        ovr = 1'b1;
      end
      if (nxt > card_start + (64'd1 << TB_CARD_LOG2)) begin
        push_entry(card, start - card_start, ovr, nxt < end_pos);
        card       = card_of(nxt);
        card_start = card << TB_CARD_LOG2;
      end
      next_pos = nxt;
      cur_card = card[23:0];
      if (nxt >= end_pos) begin
        push_entry(card, end_pos - card_start, ovr, 1'b1);
      end
    endfunction

    function void check_entry(out_t got);
      out_t want;
      if (expected_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected entry: card=%0d units=%0d overrun=%0b last=%0b",
                   got.card_index, got.offset_units, got.overrun, got.last);
        end
        return;
      end
      want = expected_entries.pop_front();
      if (got.card_index != want.card_index || got.offset_units != want.offset_units ||
          got.overrun != want.overrun || got.last != want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("entry mismatch: expected card=%0d units=%0d overrun=%0b last=%0b",
                   want.card_index, want.offset_units, want.overrun, want.last);
          $display("                got      card=%0d units=%0d overrun=%0b last=%0b",
                   got.card_index, got.offset_units, got.overrun, got.last);
        end
      end
    endfunction
  endclass

endpackage

@@ tb/card_crossing_map_builder_top_test.sv @@
`timescale 1ns / 1ps
module card_crossing_map_builder_top_test;
  import ccmb_pkg::*;
  import ccmb_tb_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STUCK_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int TARGET_ITEMS  = 1450;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;

  crossing_map_checker board;
  bit                  long_hold  = 1'b0;
  bit                  gaps_on    = 1'b1;
  int                  burst_left = 0;
  int                  counted    = 0;
  logic [31:0]         cur_old    = '0;

  card_crossing_map_builder_top #(
    .CARD_LOG2    (TB_CARD_LOG2),
    .OFFSET_SCALE (TB_OFFSET_SCALE)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        board.note_request(in_data);
      end
      if (out_valid && !out_stall) begin
        board.check_entry(out_data);
      end
    end
  end

  // The receiver switches between stall patterns on its own and, when asked, holds off for
  // a long stretch so that the result queue fills and the block stalls its input.
  initial begin
    int stall_mode;
    int mode_left;
    int tick;
    stall_mode = 0;
    mode_left  = 0;
    tick       = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 4) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 2) != 0);
          end
          default: begin
            out_stall <= ((tick % 9) < 4);
          end
        endcase
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic offer_request(input action_t act, input logic [31:0] size);
    in_t req;
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    counted++;
    req.action      = act;
    req.object_size = size;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    board.write_reg(idx, val);
    if (idx == REG_OLD_GEN_SIZE) begin
      cur_old = val;
    end
  endtask

  initial begin
    int          phase;
    int          r;
    action_t     act;
    logic [31:0] size;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero sizes, a card crossing, an overrun that crosses cards, and an exact end.
    write_reg(REG_OLD_GEN_SIZE, 32'd1000);
    write_reg(REG_FIRST_OFFSET, 32'd16);
    offer_request(ACT_OBJECT, 32'd0);
    offer_request(ACT_OBJECT, 32'd100);
    offer_request(ACT_OBJECT, 32'd200);
    offer_request(ACT_OBJECT, 32'd0);
    offer_request(ACT_OBJECT, 32'hFFFF_FFFF);
    offer_request(ACT_OBJECT, 32'd5);
    offer_request(ACT_RESTART, 32'd0);
    offer_request(ACT_OBJECT, 32'd984);
    offer_request(ACT_RESTART, 32'hFFFF_FFFF);
    settle();

    // The first object lies past the end, then exactly at it.
    write_reg(REG_OLD_GEN_SIZE, 32'd200);
    write_reg(REG_FIRST_OFFSET, 32'd255);
    offer_request(ACT_OBJECT, 32'd10);
    offer_request(ACT_RESTART, 32'd0);
    settle();
    write_reg(REG_FIRST_OFFSET, 32'd200);
    offer_request(ACT_OBJECT, 32'd10);
    offer_request(ACT_RESTART, 32'd0);
    settle();

    // An empty old generation gives nothing.
    write_reg(REG_OLD_GEN_SIZE, 32'd0);
    offer_request(ACT_OBJECT, 32'd7);
    offer_request(ACT_RESTART, 32'd0);
    settle();

    // The largest old generation.
    write_reg(REG_OLD_GEN_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_FIRST_OFFSET, 32'd0);
    offer_request(ACT_OBJECT, 32'h7FFF_FFFF);
    offer_request(ACT_OBJECT, 32'h8000_0000);
    offer_request(ACT_OBJECT, 32'd1);
    offer_request(ACT_RESTART, 32'd0);
    offer_request(ACT_OBJECT, 32'hFFFF_FFFF);
    offer_request(ACT_RESTART, 32'd0);
    settle();
    write_reg(REG_FIRST_OFFSET, 32'd255);
    offer_request(ACT_OBJECT, 32'hFFFF_FFFF);
    offer_request(ACT_RESTART, 32'd0);
    settle();

    // A completed build resumes once the old generation grows.
    write_reg(REG_OLD_GEN_SIZE, 32'd300);
    write_reg(REG_FIRST_OFFSET, 32'd0);
    offer_request(ACT_OBJECT, 32'd400);
    settle();
    write_reg(REG_OLD_GEN_SIZE, 32'd2000);
    offer_request(ACT_OBJECT, 32'd100);
    offer_request(ACT_RESTART, 32'd0);

    phase = 0;
    while (counted < TARGET_ITEMS) begin
      settle();
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        write_reg(REG_OLD_GEN_SIZE, 32'hFFFF_FFFF);
        long_hold = 1'b1;
        gaps_on   = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          write_reg(REG_OLD_GEN_SIZE, $urandom_range(1, 16) * 256 + $urandom_range(0, 255));
        end else if (r < 70) begin
          write_reg(REG_OLD_GEN_SIZE, cur_old + $urandom_range(1, 2000));
        end else if (r < 78) begin
          write_reg(REG_OLD_GEN_SIZE, 32'hFFFF_FFFF);
        end else if (r < 84) begin
          write_reg(REG_OLD_GEN_SIZE, 32'd0);
        end else if (r < 95) begin
          write_reg(REG_OLD_GEN_SIZE, $urandom);
        end
        if ($urandom_range(0, 7) == 0) begin
          long_hold = 1'b1;
        end
      end
      r = $urandom_range(0, 99);
      if (r < 20) begin
        write_reg(REG_FIRST_OFFSET, 32'd0);
      end else if (r < 35) begin
        write_reg(REG_FIRST_OFFSET, 32'd255);
      end else if (r < 60) begin
        write_reg(REG_FIRST_OFFSET, $urandom_range(0, 255));
      end
      repeat ($urandom_range(60, 200)) begin
        if (counted < TARGET_ITEMS) begin
          if (board.build_complete()) begin
            act = ($urandom_range(0, 1) == 0) ? ACT_RESTART : ACT_OBJECT;
          end else begin
            act = ($urandom_range(0, 29) == 0) ? ACT_RESTART : ACT_OBJECT;
          end
          r = $urandom_range(0, 99);
          if (r < 70) begin
            size = $urandom_range(0, 300);
          end else if (r < 85) begin
            size = $urandom_range(0, 2000);
          end else if (r < 95) begin
            size = $urandom;
          end else if (r < 97) begin
            size = 32'hFFFF_FFFF;
          end else begin
            size = 32'd256;
          end
          offer_request(act, size);
        end
      end
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
